// ----- sv/tpt_pkg.sv -----
// Shared types, codes and command/status structs for the timer slot table.
package tpt_pkg;

	localparam int SLOT_COUNT_DEF = 8;
	localparam int MAX_FIRE       = 8;
	localparam int FIRE_CNT_W     = $clog2(MAX_FIRE + 1);
	localparam int MS_W           = 32;

	typedef logic [1:0]      func_t;
	typedef logic [7:0]      act_id_t;
	typedef logic [MS_W-1:0] ms_t;

	localparam func_t FUNC_ONESHOT  = 2'd0;
	localparam func_t FUNC_PERIODIC = 2'd1;
	localparam func_t FUNC_CANCEL   = 2'd2;
	localparam func_t FUNC_TICK     = 2'd3;

	localparam logic RES_ACK   = 1'b0;
	localparam logic RES_FIRED = 1'b1;

	typedef struct packed {
		act_id_t action;
		logic    periodic;
		ms_t     interval;
		ms_t     start;
		ms_t     fired;
	} slot_t;

	typedef struct packed {
		logic in_ready;
		logic idx_inc;
		logic rd_en;
		logic wr_sched;
		logic wr_clear;
		logic wr_fire;
		logic div_start;
		logic emit_ack;
		logic ack_ok;
		logic emit_pend;
		logic pend_last;
	} cmd_t;

	typedef struct packed {
		logic  in_valid;
		func_t func;
		logic  id_zero;
		logic  rd_free;
		logic  rd_match;
		logic  rd_live;
		logic  rd_periodic;
		logic  oneshot_due;
		logic  div_done;
		logic  periodic_due;
		logic  idx_last;
		logic  out_free;
		logic  pend_valid;
		logic  cnt_last;
	} stat_t;

endpackage

// ----- sv/tpt_in_if.sv -----
// Request channel: function code, action id, interval and current time.
interface tpt_in_if;
	import tpt_pkg::*;

	logic    valid;
	logic    ready;
	func_t   func;
	act_id_t action_id;
	ms_t     interval_ms;
	ms_t     now_ms;

	modport source(output valid, func, action_id, interval_ms, now_ms, input ready);
	modport sink(input valid, func, action_id, interval_ms, now_ms, output ready);
endinterface

// ----- sv/tpt_out_if.sv -----
// Result channel: acknowledgements and fired action ids.
interface tpt_out_if;
	import tpt_pkg::*;

	logic    valid;
	logic    ready;
	logic    result_kind;
	act_id_t fired_id;
	logic    ok;
	logic    last;

	modport source(output valid, result_kind, fired_id, ok, last, input ready);
	modport sink(input valid, result_kind, fired_id, ok, last, output ready);
endinterface

// ----- sv/tpt_div.sv -----
// Restoring 32-bit unsigned divider, one quotient bit per cycle.
module tpt_div (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  tpt_pkg::ms_t dividend,
	input  tpt_pkg::ms_t divisor,
	output logic         done,
	output tpt_pkg::ms_t quotient
);
	import tpt_pkg::*;

	localparam int STEP_W = $clog2(MS_W);

	ms_t             rem_q;
	ms_t             quo_q;
	ms_t             dvs_q;
	logic [STEP_W-1:0] step_q;
	logic            busy_q;
	logic            done_q;

	logic [MS_W:0] rem_sh;
	logic [MS_W:0] diff;
	logic          ge;
	ms_t           rem_next;

	always_comb begin
		rem_sh   = {rem_q, quo_q[MS_W-1]};
		diff     = rem_sh - {1'b0, dvs_q};
		ge       = ~diff[MS_W];
		rem_next = ge ? diff[MS_W-1:0] : rem_sh[MS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			if (step_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quo_q  <= dividend;
			dvs_q  <= divisor;
			step_q <= '1;
		end else if (busy_q) begin
			rem_q  <= rem_next;
			quo_q  <= {quo_q[MS_W-2:0], ge};
			step_q <= step_q - 1'b1;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- sv/tpt_datapath.sv -----
// Slot memory, valid bits, request and read registers, divider and result register.
module tpt_datapath #(
	parameter int SLOT_COUNT = tpt_pkg::SLOT_COUNT_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	tpt_in_if.sink         req,
	tpt_out_if.source      rsp,
	input  tpt_pkg::cmd_t  cmd,
	output tpt_pkg::stat_t stat
);
	import tpt_pkg::*;

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SLOT_COUNT - 1);

	// request captured at the input transfer
	func_t   req_func_q;
	act_id_t req_id_q;
	ms_t     req_interval_q;
	ms_t     req_now_q;

	logic [IDX_W-1:0]      idx_q;
	slot_t                 mem [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] valid_q;
	slot_t                 rd_entry_q;
	logic                  rd_valid_q;

	act_id_t               pend_id_q;
	logic                  pend_valid_q;
	logic [FIRE_CNT_W-1:0] fire_cnt_q;

	logic    out_valid_q;
	logic    out_kind_q;
	act_id_t out_id_q;
	logic    out_ok_q;
	logic    out_last_q;

	logic  accept;
	logic  mem_we;
	slot_t wr_entry;
	ms_t   elapsed;
	logic  div_done;
	ms_t   div_quo;
	logic  out_free;

	assign accept    = req.valid & cmd.in_ready;
	assign req.ready = cmd.in_ready;
	assign elapsed   = req_now_q - rd_entry_q.start;
	assign out_free  = ~out_valid_q | rsp.ready;

	tpt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (elapsed),
		.divisor  (rd_entry_q.interval),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			req_func_q     <= req.func;
			req_id_q       <= req.action_id;
			req_interval_q <= req.interval_ms;
			req_now_q      <= req.now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (accept) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_comb begin
		mem_we   = cmd.wr_sched | (cmd.wr_fire & rd_entry_q.periodic);
		wr_entry = rd_entry_q;
		if (cmd.wr_sched) begin
			wr_entry.action   = req_id_q;
			wr_entry.periodic = req_func_q[0];
			wr_entry.interval = req_interval_q;
			wr_entry.start    = req_now_q;
			wr_entry.fired    = '0;
		end else begin
			wr_entry.fired    = div_quo;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[idx_q] <= wr_entry;
		end
		if (cmd.rd_en) begin
			rd_entry_q <= mem[idx_q];
		end
	end

	// a freed slot keeps its old contents in memory: only the valid bit is cleared
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (cmd.wr_sched) begin
				valid_q[idx_q] <= 1'b1;
			end else if (cmd.wr_clear || (cmd.wr_fire && !rd_entry_q.periodic)) begin
				valid_q[idx_q] <= 1'b0;
			end
			if (cmd.rd_en) begin
				rd_valid_q <= valid_q[idx_q];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			fire_cnt_q   <= '0;
		end else if (accept) begin
			pend_valid_q <= 1'b0;
			fire_cnt_q   <= '0;
		end else if (cmd.wr_fire) begin
			pend_valid_q <= 1'b1;
			fire_cnt_q   <= fire_cnt_q + 1'b1;
		end else if (cmd.emit_pend && cmd.pend_last) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_fire) begin
			pend_id_q <= rd_entry_q.action;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_ack || cmd.emit_pend) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_ack) begin
			out_kind_q <= RES_ACK;
			out_id_q   <= '0;
			out_ok_q   <= cmd.ack_ok;
			out_last_q <= 1'b1;
		end else if (cmd.emit_pend) begin
			out_kind_q <= RES_FIRED;
			out_id_q   <= pend_id_q;
			out_ok_q   <= 1'b1;
			out_last_q <= cmd.pend_last;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.result_kind = out_kind_q;
	assign rsp.fired_id    = out_id_q;
	assign rsp.ok          = out_ok_q;
	assign rsp.last        = out_last_q;

	always_comb begin
		stat.in_valid     = req.valid;
		stat.func         = req_func_q;
		stat.id_zero      = (req_id_q == '0);
		stat.rd_free      = ~rd_valid_q;
		stat.rd_match     = rd_valid_q & (rd_entry_q.action == req_id_q);
		stat.rd_live      = rd_valid_q & (rd_entry_q.interval != '0);
		stat.rd_periodic  = rd_entry_q.periodic;
		stat.oneshot_due  = (elapsed >= rd_entry_q.interval);
		stat.div_done     = div_done;
		stat.periodic_due = (div_quo > rd_entry_q.fired);
		stat.idx_last     = (idx_q == IDX_LAST);
		stat.out_free     = out_free;
		stat.pend_valid   = pend_valid_q;
		stat.cnt_last     = (fire_cnt_q == FIRE_CNT_W'(MAX_FIRE - 1));
	end

	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_ack || cmd.emit_pend) |-> (!out_valid_q || rsp.ready))
		else $error("result loaded while output register still full");

	a_fire_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fire_cnt_q <= FIRE_CNT_W'(MAX_FIRE))
		else $error("fire count above cap");

	a_sched_id: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_sched |-> (req_id_q != '0))
		else $error("slot scheduled with id zero");

	a_fire_live: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_fire |-> (rd_valid_q && rd_entry_q.interval != '0))
		else $error("fired a free or zero-interval slot");

endmodule

// ----- sv/tpt_ctrl.sv -----
// Sequencer: slot scan for schedule, cancel and tick, divider wait, result emission.
module tpt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  tpt_pkg::stat_t stat,
	output tpt_pkg::cmd_t  cmd
);
	import tpt_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_READ   = 4'd1;
	localparam logic [3:0] S_CHECK  = 4'd2;
	localparam logic [3:0] S_DIV    = 4'd3;
	localparam logic [3:0] S_FIRE   = 4'd4;
	localparam logic [3:0] S_NEXT   = 4'd5;
	localparam logic [3:0] S_FLUSH  = 4'd6;
	localparam logic [3:0] S_ACK_OK = 4'd7;
	localparam logic [3:0] S_ACK_NO = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				if (stat.in_valid) begin
					state_d = S_READ;
				end
			end
			S_READ: begin
				cmd.rd_en = 1'b1;
				state_d   = S_CHECK;
			end
			S_CHECK: begin
				unique case (stat.func) inside
					FUNC_ONESHOT, FUNC_PERIODIC: begin
						if (stat.id_zero) begin
							state_d = S_ACK_NO;
						end else if (stat.rd_free || stat.rd_match) begin
							cmd.wr_sched = 1'b1;
							state_d      = S_ACK_OK;
						end else if (stat.idx_last) begin
							state_d = S_ACK_NO;
						end else begin
							cmd.idx_inc = 1'b1;
							state_d     = S_READ;
						end
					end
					FUNC_CANCEL: begin
						if (stat.id_zero) begin
							state_d = S_ACK_NO;
						end else if (stat.rd_match) begin
							cmd.wr_clear = 1'b1;
							state_d      = S_ACK_OK;
						end else if (stat.idx_last) begin
							state_d = S_ACK_NO;
						end else begin
							cmd.idx_inc = 1'b1;
							state_d     = S_READ;
						end
					end
					default: begin
						if (!stat.rd_live) begin
							state_d = S_NEXT;
						end else if (stat.rd_periodic) begin
							cmd.div_start = 1'b1;
							state_d       = S_DIV;
						end else if (stat.oneshot_due) begin
							state_d = S_FIRE;
						end else begin
							state_d = S_NEXT;
						end
					end
				endcase
			end
			S_DIV: begin
				if (stat.div_done) begin
					state_d = stat.periodic_due ? S_FIRE : S_NEXT;
				end
			end
			S_FIRE: begin
				// the previous firing goes out now; this one waits for a successor or the end
				if (!stat.pend_valid || stat.out_free) begin
					cmd.wr_fire   = 1'b1;
					cmd.emit_pend = stat.pend_valid;
					state_d       = stat.cnt_last ? S_FLUSH : S_NEXT;
				end
			end
			S_NEXT: begin
				if (stat.idx_last) begin
					state_d = S_FLUSH;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_READ;
				end
			end
			S_FLUSH: begin
				if (!stat.pend_valid) begin
					state_d = S_IDLE;
				end else if (stat.out_free) begin
					cmd.emit_pend = 1'b1;
					cmd.pend_last = 1'b1;
					state_d       = S_IDLE;
				end
			end
			S_ACK_OK: begin
				if (stat.out_free) begin
					cmd.emit_ack = 1'b1;
					cmd.ack_ok   = 1'b1;
					state_d      = S_IDLE;
				end
			end
			S_ACK_NO: begin
				if (stat.out_free) begin
					cmd.emit_ack = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ----- sv/one_shot_periodic_timer_table_core.sv -----
// Timer slot table top level: one-shot and periodic timers, scanned per request.
//
//  channel | dir | payload                                   | transfer
//  req     | in  | func, action_id, interval_ms, now_ms      | valid & ready
//  rsp     | out | result_kind, fired_id, ok, last           | valid & ready
//
// One request at a time. Schedule/cancel: each slot examined takes a read and a check step,
// then the ack follows. Tick: read, check and next steps per slot, plus a wait in the bit-serial
// divider for each live periodic slot and a fire step for each firing.
// Reset clears all slot valid bits at once; no clearing pass is needed.
// A full result register holds the scan at the next emission until rsp takes it.
module one_shot_periodic_timer_table_core #(
	parameter int SLOT_COUNT = tpt_pkg::SLOT_COUNT_DEF
) (
	input logic       clk,
	input logic       arst_n,
	tpt_in_if.sink    req,
	tpt_out_if.source rsp
);
	import tpt_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	tpt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	tpt_datapath #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cmd    (cmd),
		.stat   (stat)
	);

endmodule

// ----- test/tb.sv -----
// Testbench for the timer slot table: directed rows, then random requests checked by a predictor.
`timescale 1ns / 1ps

module tb;
	import tpt_pkg::*;

	localparam int SLOTS        = SLOT_COUNT_DEF;
	localparam int RANDOM_ITEMS = 105;
	localparam int QUIET_LIMIT  = 4000;
	localparam int END_WAIT     = 400;
	localparam int SHOW_MAX     = 10;

	typedef struct packed {
		logic    kind;
		act_id_t id;
		logic    ok;
		logic    is_last;
	} reply_t;

	typedef struct packed {
		func_t   func;
		act_id_t id;
		ms_t     interval;
		ms_t     now;
		logic    typed;
		logic    ack_ok;
	} req_row_t;

	localparam int DIR_ROWS = 25;
	// typed = 1: the ack is written here, otherwise the predictor decides
	localparam req_row_t DIR_TABLE [DIR_ROWS] = '{
		'{FUNC_CANCEL,   8'd5,   32'd0,           32'd0,           1'b1, 1'b0},
		'{FUNC_ONESHOT,  8'd0,   32'd10,          32'd0,           1'b1, 1'b0},
		'{FUNC_CANCEL,   8'd0,   32'd0,           32'd0,           1'b1, 1'b0},
		'{FUNC_ONESHOT,  8'd1,   32'd10,          32'd100,         1'b1, 1'b1},
		'{FUNC_PERIODIC, 8'd255, 32'hFFFF_FFFF,   32'hFFFF_FFFF,   1'b1, 1'b1},
		'{FUNC_ONESHOT,  8'd2,   32'd0,           32'd0,           1'b1, 1'b1},
		'{FUNC_TICK,     8'd0,   32'd0,           32'd109,         1'b0, 1'b0},
		'{FUNC_TICK,     8'hAA,  32'h5555_5555,   32'd110,         1'b0, 1'b0},
		'{FUNC_PERIODIC, 8'd2,   32'd3,           32'd110,         1'b0, 1'b0},
		'{FUNC_PERIODIC, 8'd3,   32'd7,           32'd200,         1'b0, 1'b0},
		'{FUNC_TICK,     8'd0,   32'd0,           32'd221,         1'b0, 1'b0},
		'{FUNC_ONESHOT,  8'd3,   32'd5,           32'd230,         1'b0, 1'b0},
		'{FUNC_CANCEL,   8'd2,   32'd0,           32'd0,           1'b1, 1'b1},
		'{FUNC_PERIODIC, 8'd4,   32'd1,           32'hFFFF_FFF0,   1'b0, 1'b0},
		'{FUNC_TICK,     8'd0,   32'd0,           32'h0000_0010,   1'b0, 1'b0},
		'{FUNC_CANCEL,   8'd255, 32'd0,           32'd0,           1'b1, 1'b1},
		'{FUNC_ONESHOT,  8'd10,  32'd1,           32'd300,         1'b1, 1'b1},
		'{FUNC_PERIODIC, 8'd11,  32'd2,           32'd300,         1'b1, 1'b1},
		'{FUNC_ONESHOT,  8'd12,  32'd3,           32'd300,         1'b1, 1'b1},
		'{FUNC_PERIODIC, 8'd13,  32'h8000_0000,   32'd300,         1'b1, 1'b1},
		'{FUNC_ONESHOT,  8'd14,  32'd1000,        32'd300,         1'b1, 1'b1},
		'{FUNC_PERIODIC, 8'd15,  32'd9,           32'd300,         1'b1, 1'b1},
		'{FUNC_ONESHOT,  8'd16,  32'd1,           32'd300,         1'b1, 1'b0},
		'{FUNC_ONESHOT,  8'd2,   32'd1,           32'd300,         1'b0, 1'b0},
		'{FUNC_TICK,     8'd0,   32'd0,           32'h0000_0100,   1'b0, 1'b0}
	};

	logic clk = 1'b0;
	logic arst_n;

	tpt_in_if  req_ch ();
	tpt_out_if rsp_ch ();

	one_shot_periodic_timer_table_core #(
		.SLOT_COUNT(SLOTS)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	always #5 clk = ~clk;

	// shadow copy of the slot table
	act_id_t slot_id  [SLOTS];
	logic    slot_per [SLOTS];
	ms_t     slot_iv  [SLOTS];
	ms_t     slot_t0  [SLOTS];
	ms_t     slot_cnt [SLOTS];

	reply_t reply_q[$];
	reply_t seen_reply, owed_reply;

	logic typed_ack, typed_ok;
	bit   sender_calm;
	ms_t  ms_clock;

	int mismatches, quiet_cycles, sent_count;
	int n_sched, n_cancel, n_tick, n_acks, n_fires, widest_burst;

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			slot_id[i]  = '0;
			slot_per[i] = 1'b0;
			slot_iv[i]  = '0;
			slot_t0[i]  = '0;
			slot_cnt[i] = '0;
		end
	end

	function automatic void free_slot(int i);
		slot_id[i]  = '0;
		slot_per[i] = 1'b0;
		slot_iv[i]  = '0;
		slot_t0[i]  = '0;
		slot_cnt[i] = '0;
	endfunction

	// apply one request to the shadow table, queue the replies it owes
	function automatic void table_apply(func_t f, act_id_t id, ms_t iv, ms_t now);
		bit  hit;
		bit  due;
		int  n;
		ms_t elapsed, quot;
		hit = 1'b0;
		n   = 0;
		if (f == FUNC_ONESHOT || f == FUNC_PERIODIC) begin
			if (id != '0) begin
				for (int i = 0; i < SLOTS; i++) begin
					if (!hit && (slot_id[i] == '0 || slot_id[i] == id)) begin
						slot_id[i]  = id;
						slot_per[i] = (f == FUNC_PERIODIC);
						slot_iv[i]  = iv;
						slot_t0[i]  = now;
						slot_cnt[i] = '0;
						hit = 1'b1;
					end
				end
			end
			reply_q.push_back(reply_t'{RES_ACK, 8'd0, hit, 1'b1});
		end else if (f == FUNC_CANCEL) begin
			if (id != '0) begin
				for (int i = 0; i < SLOTS; i++) begin
					if (!hit && slot_id[i] == id) begin
						free_slot(i);
						hit = 1'b1;
					end
				end
			end
			reply_q.push_back(reply_t'{RES_ACK, 8'd0, hit, 1'b1});
		end else begin
			for (int i = 0; i < SLOTS; i++) begin
				if (n < MAX_FIRE && slot_id[i] != '0 && slot_iv[i] != '0) begin
					elapsed = now - slot_t0[i];
					quot    = elapsed / slot_iv[i];
					due     = slot_per[i] ? (quot > slot_cnt[i]) : (elapsed >= slot_iv[i]);
					if (due) begin
						reply_q.push_back(reply_t'{RES_FIRED, slot_id[i], 1'b1, 1'b0});
						n++;
						if (slot_per[i])
							slot_cnt[i] = quot;
						else
							free_slot(i);
					end
				end
			end
			if (n > 0)
				reply_q[reply_q.size() - 1].is_last = 1'b1;
			if (n > widest_burst)
				widest_burst = n;
		end
	endfunction

	// request side: prediction on each transfer; result side: checking; plus watchdog
	always @(posedge clk) begin
		if (req_ch.valid && req_ch.ready) begin
			table_apply(req_ch.func, req_ch.action_id, req_ch.interval_ms, req_ch.now_ms);
			if (typed_ack)
				reply_q[reply_q.size() - 1] = reply_t'{RES_ACK, 8'd0, typed_ok, 1'b1};
			case (req_ch.func)
				FUNC_ONESHOT, FUNC_PERIODIC: n_sched++;
				FUNC_CANCEL: n_cancel++;
				default: n_tick++;
			endcase
		end
		if (rsp_ch.valid && rsp_ch.ready) begin
			seen_reply = reply_t'{rsp_ch.result_kind, rsp_ch.fired_id, rsp_ch.ok, rsp_ch.last};
			if (seen_reply.kind == RES_FIRED)
				n_fires++;
			else
				n_acks++;
			if (reply_q.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOW_MAX)
					$display("%0t: unexpected reply kind=%0d id=%0d ok=%0d last=%0d", $time,
						seen_reply.kind, seen_reply.id, seen_reply.ok, seen_reply.is_last);
			end else begin
				owed_reply = reply_q.pop_front();
				if (seen_reply !== owed_reply) begin
					mismatches++;
					if (mismatches <= SHOW_MAX)
						$display("%0t: reply mismatch exp kind=%0d id=%0d ok=%0d last=%0d, got kind=%0d id=%0d ok=%0d last=%0d",
							$time, owed_reply.kind, owed_reply.id, owed_reply.ok,
							owed_reply.is_last, seen_reply.kind, seen_reply.id,
							seen_reply.ok, seen_reply.is_last);
				end
			end
		end
		if (arst_n === 1'b1) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles, %0d replies outstanding",
					quiet_cycles, reply_q.size());
				$display("tb failed");
				$finish;
			end
		end
	end

	task automatic send(func_t f, act_id_t id, ms_t iv, ms_t now, logic typed, logic ack_ok);
		int unsigned gap;
		gap = sender_calm ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.func        <= f;
		req_ch.action_id   <= id;
		req_ch.interval_ms <= iv;
		req_ch.now_ms      <= now;
		typed_ack          <= typed;
		typed_ok           <= ack_ok;
		do @(posedge clk); while (!req_ch.ready);
		sent_count++;
		if (sent_count % 20 == 0)
			sender_calm = ($urandom_range(0, 3) == 0);
	endtask

	// hold off until every owed reply has come back
	task automatic drain_replies();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (reply_q.size() != 0) @(posedge clk);
	endtask

	// mostly well-formed traffic on a small id pool and an advancing clock, some noise
	task automatic random_request();
		int unsigned pick, sel;
		func_t       f;
		act_id_t     id;
		ms_t         iv, now;
		pick = $urandom_range(0, 99);
		f    = FUNC_TICK;
		id   = act_id_t'($urandom_range(0, 255));
		iv   = $urandom;
		now  = ms_clock;
		if (pick < 8) begin
			f   = func_t'($urandom_range(0, 3));
			now = $urandom;
		end else if (pick < 11) begin
			// park the clock just short of the 32-bit wrap
			ms_clock = 32'hFFFF_FFFF - $urandom_range(0, 200);
			now = ms_clock;
		end else if (pick < 45) begin
			ms_clock = ms_clock + $urandom_range(0, 40);
			now = ms_clock;
		end else if (pick < 82) begin
			f = ($urandom_range(0, 1) != 0) ? FUNC_PERIODIC : FUNC_ONESHOT;
			if ($urandom_range(0, 9) != 0)
				id = act_id_t'($urandom_range(1, 12));
			sel = $urandom_range(0, 9);
			if (sel == 0)
				iv = '0;
			else if (sel > 1)
				iv = $urandom_range(1, 60);
		end else begin
			f = FUNC_CANCEL;
			sel = $urandom_range(0, 9);
			if (sel == 0)
				id = '0;
			else if (sel > 1)
				id = act_id_t'($urandom_range(1, 12));
		end
		send(f, id, iv, now, 1'b0, 1'b0);
	endtask

	// result side: random stalls per transfer, with calm stretches
	initial begin
		int unsigned stall;
		int          taken;
		bit          calm;
		taken = 0;
		calm  = 1'b0;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 10);
			if (stall != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			taken++;
			if (taken % 16 == 0)
				calm = ($urandom_range(0, 2) == 0);
		end
	end

	initial begin
		mismatches   = 0;
		quiet_cycles = 0;
		sent_count   = 0;
		n_sched      = 0;
		n_cancel     = 0;
		n_tick       = 0;
		n_acks       = 0;
		n_fires      = 0;
		widest_burst = 0;
		sender_calm  = 1'b0;
		ms_clock     = 32'd1000;
		arst_n             <= 1'b0;
		req_ch.valid       <= 1'b0;
		req_ch.func        <= FUNC_TICK;
		req_ch.action_id   <= '0;
		req_ch.interval_ms <= '0;
		req_ch.now_ms      <= '0;
		typed_ack          <= 1'b0;
		typed_ok           <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < DIR_ROWS; r++)
			send(DIR_TABLE[r].func, DIR_TABLE[r].id, DIR_TABLE[r].interval,
				DIR_TABLE[r].now, DIR_TABLE[r].typed, DIR_TABLE[r].ack_ok);
		drain_replies();

		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			random_request();
			if (k == RANDOM_ITEMS / 2)
				drain_replies();
		end
		drain_replies();
		repeat (END_WAIT) @(posedge clk);

		$display("covered %0d requests: %0d schedules, %0d cancels, %0d ticks, widest tick burst %0d",
			n_sched + n_cancel + n_tick, n_sched, n_cancel, n_tick, widest_burst);
		$display("checked %0d acks and %0d firings, %0d mismatches",
			n_acks, n_fires, mismatches);
		if (mismatches == 0 && reply_q.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
